>>> src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and tables of the pmt pulse shape core.
// ----------------------------------------------------------------------------
package pps_pkg;

  // default parameter values
  localparam int TIME_BITS_DEF = 20;
  localparam int AMP_BITS_DEF  = 16;

  // register field widths
  localparam int RATE_W   = 24;
  localparam int FRAC_W   = 17;
  localparam int CFG_IDX_W = 3;

  // fixed point formats of the exponential
  localparam int ARG_W = 29;               // clamped UQ.24 exponent argument
  localparam int Y_W   = 30;               // a/16 in Q30
  localparam int EXP_W = 31;               // UQ2.30, at most one
  localparam int MIX_W = 47;               // weighted sum, UQ.46

  localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(29'd16 << 24);
  localparam logic [26:0] GAUSS_U_LIMIT = 27'd6 << 24;
  localparam logic [EXP_W-1:0] Q30_ONE  = EXP_W'(31'd1 << 30);
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  // series length and reciprocals floor(2^31 / n) for n = 1 .. 12
  localparam int SERIES_TERMS = 12;
  localparam logic [31:0] RECIP_TAB [13] = '{
    32'd0,         32'd2147483648, 32'd1073741824, 32'd715827882,
    32'd536870912, 32'd429496729,  32'd357913941,  32'd306783378,
    32'd268435456, 32'd238609294,  32'd214748364,  32'd195225786,
    32'd178956970
  };

  // pipeline depths
  localparam int FRONT_LAT = 3;
  localparam int EXP_LAT   = 2 * SERIES_TERMS + 4;
  localparam int BACK_LAT  = 3;
  localparam int PIPE_LAT  = FRONT_LAT + EXP_LAT + BACK_LAT;

  // register reset values
  localparam int RST_AMP        = 4096;
  localparam int RST_RISE_LEN   = 80;
  localparam int RST_RISE_RATE  = 209715;
  localparam int RST_FALL_RATE  = 34953;
  localparam int RST_SLOW_RATE  = 1049;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_MODE    = 3'd0,
    REG_AMPLITUDE     = 3'd1,
    REG_DELAY         = 3'd2,
    REG_RISE_LENGTH   = 3'd3,
    REG_RISE_RATE     = 3'd4,
    REG_FALL_RATE     = 3'd5,
    REG_SLOW_RATE     = 3'd6,
    REG_SLOW_FRACTION = 3'd7
  } cfg_reg_e;

  // which part of the pulse a sample falls into
  typedef enum logic [1:0] {
    KIND_RISE,
    KIND_FALL,
    KIND_GAUSS
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  blank;   // before the pulse start in scintillation mode
  } side_t;

endpackage

>>> src/pps_front.sv
// ----------------------------------------------------------------------------
// pps_front
// Time differences, region select and exponent arguments (three stages).
// ----------------------------------------------------------------------------
module pps_front #(
  parameter int TW = pps_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [TW-1:0]                 sample_time_i,
  input  logic                          mode_i,
  input  logic [TW-1:0]                 delay_i,
  input  logic [TW-1:0]                 rise_len_i,
  input  logic [pps_pkg::RATE_W-1:0]    rise_rate_i,
  input  logic [pps_pkg::RATE_W-1:0]    fall_rate_i,
  input  logic [pps_pkg::RATE_W-1:0]    slow_rate_i,
  output logic                          vld_o,
  output pps_pkg::side_t                side_o,
  output logic [pps_pkg::ARG_W-1:0]     arg0_o,
  output logic [pps_pkg::ARG_W-1:0]     arg1_o
);

  localparam int MW = TW + pps_pkg::RATE_W;

  logic                    ge;
  logic [TW-1:0]           dt_abs;
  logic [TW+2:0]           sw;
  logic                    rise_part;
  logic [TW-1:0]           d2;
  pps_pkg::side_t          side1_d;
  logic [TW-1:0]           td1_d;
  logic [pps_pkg::RATE_W-1:0] rate0;
  logic [53:0]             uu;
  logic [pps_pkg::ARG_W-1:0] arg0_d, arg1_d;

  logic                    vld1_q, vld2_q, vld3_q;
  pps_pkg::side_t          side1_q, side2_q, side3_q;
  logic [TW-1:0]           td1_q;
  logic [MW-1:0]           m0_q, m1_q;
  logic [pps_pkg::ARG_W-1:0] arg0_q, arg1_q;

  // stage 1: distance to the delay and the switch point
  always_comb begin
    ge        = sample_time_i >= delay_i;
    dt_abs    = ge ? (sample_time_i - delay_i) : (delay_i - sample_time_i);
    sw        = {1'b0, rise_len_i, 2'b00} + (TW+3)'(rise_len_i);
    rise_part = (TW+3)'(dt_abs) <= sw;
    d2        = dt_abs - sw[TW-1:0];
    if (mode_i) begin
      side1_d.kind = pps_pkg::KIND_GAUSS;
    end else if (rise_part) begin
      side1_d.kind = pps_pkg::KIND_RISE;
    end else begin
      side1_d.kind = pps_pkg::KIND_FALL;
    end
    side1_d.blank = !mode_i && !ge;
    td1_d = (side1_d.kind == pps_pkg::KIND_FALL) ? d2 : dt_abs;
  end

  // stage 2 rate select
  assign rate0 = (side1_q.kind == pps_pkg::KIND_FALL) ? fall_rate_i : rise_rate_i;

  // stage 3: gaussian square and argument clamp
  always_comb begin
    uu = 54'(m0_q[26:0]) * 54'(m0_q[26:0]);
    if (side2_q.kind == pps_pkg::KIND_GAUSS) begin
      arg0_d = (m0_q < MW'(pps_pkg::GAUSS_U_LIMIT)) ? uu[53:25] : pps_pkg::ARG_LIMIT;
    end else begin
      arg0_d = (m0_q >= MW'(pps_pkg::ARG_LIMIT)) ? pps_pkg::ARG_LIMIT
                                                  : m0_q[pps_pkg::ARG_W-1:0];
    end
    arg1_d = (m1_q >= MW'(pps_pkg::ARG_LIMIT)) ? pps_pkg::ARG_LIMIT
                                                : m1_q[pps_pkg::ARG_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      td1_q   <= td1_d;
      side2_q <= side1_q;
      m0_q    <= MW'(td1_q) * MW'(rate0);
      m1_q    <= MW'(td1_q) * MW'(slow_rate_i);
      side3_q <= side2_q;
      arg0_q  <= arg0_d;
      arg1_q  <= arg1_d;
    end
  end

  assign vld_o  = vld3_q;
  assign side_o = side3_q;
  assign arg0_o = arg0_q;
  assign arg1_o = arg1_q;

endmodule

>>> src/pps_exp.sv
// ----------------------------------------------------------------------------
// pps_exp
// Pipelined exp(-a): twelve series terms of two stages, then four squarings.
// ----------------------------------------------------------------------------
module pps_exp (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pps_pkg::ARG_W-1:0]   arg_i,
  output logic [pps_pkg::EXP_W-1:0]   exp_o
);

  localparam int T   = pps_pkg::SERIES_TERMS;
  localparam int YW  = pps_pkg::Y_W;
  localparam int EW  = pps_pkg::EXP_W;
  localparam int PW  = YW + EW;
  localparam int QPW = YW + 32;
  localparam int SQW = 2 * EW;

  logic [YW-1:0] y_in  [T];
  logic          z_in  [T];
  logic [EW-1:0] v_in  [T];
  logic [EW-1:0] v_out [T];

  logic [YW-1:0] ya_q [T];
  logic          za_q [T];
  logic [PW-1:0] pa_q [T];
  logic [YW-1:0] yb_q [T];
  logic          zb_q [T];
  logic [YW-1:0] xb_q [T];
  logic [YW-1:0] qb_q [T];

  logic [EW-1:0] s_in [4];
  logic [EW-1:0] s_q  [4];
  logic          zs_q [4];

  for (genvar i = 0; i < T; i++) begin : g_term
    localparam int N = T - i;
    logic [QPW-1:0] qp;
    logic [YW-1:0]  rem;
    logic [YW-1:0]  q;

    if (i == 0) begin : g_first
      assign y_in[i] = {arg_i[pps_pkg::ARG_W-2:0], 2'b00};
      assign z_in[i] = arg_i[pps_pkg::ARG_W-1];
      assign v_in[i] = pps_pkg::Q30_ONE;
    end else begin : g_next
      assign y_in[i] = yb_q[i-1];
      assign z_in[i] = zb_q[i-1];
      assign v_in[i] = v_out[i-1];
    end

    // quotient estimate by reciprocal, then one correction step
    assign qp  = QPW'(pa_q[i][2*YW-1:YW]) * QPW'(pps_pkg::RECIP_TAB[N]);
    assign rem = xb_q[i] - YW'(qb_q[i] * YW'(N));
    assign q   = qb_q[i] + YW'(rem >= YW'(N));
    assign v_out[i] = pps_pkg::Q30_ONE - EW'(q);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ya_q[i] <= y_in[i];
        za_q[i] <= z_in[i];
        pa_q[i] <= PW'(y_in[i]) * PW'(v_in[i]);
        yb_q[i] <= ya_q[i];
        zb_q[i] <= za_q[i];
        xb_q[i] <= pa_q[i][2*YW-1:YW];
        qb_q[i] <= qp[YW+30:31];
      end
    end
  end

  // four rounded squarings give the sixteenth power
  for (genvar k = 0; k < 4; k++) begin : g_sq
    logic [SQW-1:0] sq;
    if (k == 0) begin : g_first
      assign s_in[k] = v_out[T-1];
    end else begin : g_next
      assign s_in[k] = s_q[k-1];
    end
    assign sq = SQW'(s_in[k]) * SQW'(s_in[k]) + SQW'(pps_pkg::Q30_ONE >> 1);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]  <= sq[EW+29:30];
        zs_q[k] <= (k == 0) ? zb_q[T-1] : zs_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign exp_o = zs_q[3] ? '0 : s_q[3];

endmodule

>>> src/pps_back.sv
// ----------------------------------------------------------------------------
// pps_back
// Component mix, amplitude scaling, rounding and saturation (three stages).
// ----------------------------------------------------------------------------
module pps_back #(
  parameter int AB = pps_pkg::AMP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  pps_pkg::side_t              side_i,
  input  logic [pps_pkg::EXP_W-1:0]   e0_i,
  input  logic [pps_pkg::EXP_W-1:0]   e1_i,
  input  logic [AB-1:0]               amp_i,
  input  logic [pps_pkg::FRAC_W-1:0]  frac_i,
  output logic                        vld_o,
  output logic [AB-1:0]               value_o
);

  localparam int MW  = pps_pkg::MIX_W;
  localparam int LW  = AB + 24;
  localparam int HW  = AB + MW - 24;
  localparam int SW  = AB + MW + 1;

  logic [pps_pkg::FRAC_W-1:0] f;
  logic [MW-1:0] mix_d;
  logic [SW-1:0] sum;
  logic [SW-47:0] val;

  logic          vld1_q, vld2_q, vld3_q;
  logic [MW-1:0] mix_q;
  logic [LW-1:0] pl_q;
  logic [HW-1:0] ph_q;
  logic [AB-1:0] val_q;

  // stage 1: weighted sum of the fall and slow components, or the rise or gaussian term, in UQ.46
  always_comb begin
    f = (frac_i > pps_pkg::FRAC_ONE) ? pps_pkg::FRAC_ONE : frac_i;
    case (side_i.kind)
      pps_pkg::KIND_FALL: begin
        mix_d = MW'(pps_pkg::FRAC_ONE - f) * MW'(e0_i) + MW'(f) * MW'(e1_i);
      end
      pps_pkg::KIND_RISE: begin
        mix_d = {pps_pkg::Q30_ONE - e0_i, 16'b0};
      end
      pps_pkg::KIND_GAUSS: begin
        mix_d = {e0_i, 16'b0};
      end
      default: begin
        mix_d = '0;
      end
    endcase
    if (side_i.blank) begin
      mix_d = '0;
    end
  end

  // stage 3: sum partial products, round and saturate
  always_comb begin
    sum = (SW'(ph_q) << 24) + SW'(pl_q) + (SW'(1) << 45);
    val = sum[SW-1:46];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
      pl_q  <= LW'(amp_i) * LW'(mix_q[23:0]);
      ph_q  <= HW'(amp_i) * HW'(mix_q[MW-1:24]);
      val_q <= (|val[SW-47:AB]) ? '1 : val[AB-1:0];
    end
  end

  assign vld_o   = vld3_q;
  assign value_o = val_q;

endmodule

>>> src/pmt_pulse_shape_core.sv
// ----------------------------------------------------------------------------
// pmt_pulse_shape_core
// Photomultiplier pulse value at a sample time, scintillation or gaussian.
// Pipeline: 3 front, 28 exp and 3 back stages from input transfer to result.
// Throughput: one sample per cycle; the whole pipeline holds while a result
// waits in the output register under stall.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pmt_pulse_shape_core #(
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int AMP_BITS  = pps_pkg::AMP_BITS_DEF,
  parameter int CFG_W     = (TIME_BITS > pps_pkg::RATE_W) ? TIME_BITS : pps_pkg::RATE_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [TIME_BITS-1:0]          sample_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [AMP_BITS-1:0]           pulse_value_o,
  input  logic                          cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int EL = pps_pkg::EXP_LAT;

  logic                        mode_q;
  logic [AMP_BITS-1:0]         amp_q;
  logic [TIME_BITS-1:0]        delay_q;
  logic [TIME_BITS-1:0]        rise_len_q;
  logic [pps_pkg::RATE_W-1:0]  rise_rate_q;
  logic [pps_pkg::RATE_W-1:0]  fall_rate_q;
  logic [pps_pkg::RATE_W-1:0]  slow_rate_q;
  logic [pps_pkg::FRAC_W-1:0]  frac_q;

  logic                        en;
  logic                        f_vld;
  pps_pkg::side_t              f_side;
  logic [pps_pkg::ARG_W-1:0]   arg0, arg1;
  logic [pps_pkg::EXP_W-1:0]   e0, e1;
  logic [EL-1:0]               vld_q;
  pps_pkg::side_t              side_q [EL];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      amp_q       <= AMP_BITS'(pps_pkg::RST_AMP);
      delay_q     <= '0;
      rise_len_q  <= TIME_BITS'(pps_pkg::RST_RISE_LEN);
      rise_rate_q <= pps_pkg::RATE_W'(pps_pkg::RST_RISE_RATE);
      fall_rate_q <= pps_pkg::RATE_W'(pps_pkg::RST_FALL_RATE);
      slow_rate_q <= pps_pkg::RATE_W'(pps_pkg::RST_SLOW_RATE);
      frac_q      <= '0;
    end else if (cfg_we_i) begin
      case (pps_pkg::cfg_reg_e'(cfg_idx_i))
        pps_pkg::REG_SHAPE_MODE:    mode_q      <= cfg_data_i[0];
        pps_pkg::REG_AMPLITUDE:     amp_q       <= cfg_data_i[AMP_BITS-1:0];
        pps_pkg::REG_DELAY:         delay_q     <= cfg_data_i[TIME_BITS-1:0];
        pps_pkg::REG_RISE_LENGTH:   rise_len_q  <= cfg_data_i[TIME_BITS-1:0];
        pps_pkg::REG_RISE_RATE:     rise_rate_q <= cfg_data_i[pps_pkg::RATE_W-1:0];
        pps_pkg::REG_FALL_RATE:     fall_rate_q <= cfg_data_i[pps_pkg::RATE_W-1:0];
        pps_pkg::REG_SLOW_RATE:     slow_rate_q <= cfg_data_i[pps_pkg::RATE_W-1:0];
        pps_pkg::REG_SLOW_FRACTION: frac_q      <= cfg_data_i[pps_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result waits under stall
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  pps_front #(
    .TW (TIME_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (in_valid_i),
    .sample_time_i (sample_time_i),
    .mode_i        (mode_q),
    .delay_i       (delay_q),
    .rise_len_i    (rise_len_q),
    .rise_rate_i   (rise_rate_q),
    .fall_rate_i   (fall_rate_q),
    .slow_rate_i   (slow_rate_q),
    .vld_o         (f_vld),
    .side_o        (f_side),
    .arg0_o        (arg0),
    .arg1_o        (arg1)
  );

  pps_exp u_exp0 (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (arg0),
    .exp_o (e0)
  );

  pps_exp u_exp1 (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (arg1),
    .exp_o (e1)
  );

  // valid and side information follow the exp pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[EL-2:0], f_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= f_side;
      for (int k = 1; k < EL; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  pps_back #(
    .AB (AMP_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_q[EL-1]),
    .side_i  (side_q[EL-1]),
    .e0_i    (e0),
    .e1_i    (e1),
    .amp_i   (amp_q),
    .frac_i  (frac_q),
    .vld_o   (out_valid_o),
    .value_o (pulse_value_o)
  );

endmodule

>>> src/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the pulse shape core, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker #(
  parameter int AMP_BITS = pps_pkg::AMP_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [AMP_BITS-1:0] pulse_value_o
);

  localparam int LAT = pps_pkg::PIPE_LAT;
  localparam int RW  = $clog2(LAT + 1);

  logic [RW-1:0] run_q;

  // count of cycles in a row without output stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_stall_i) begin
      run_q <= '0;
    end else if (run_q != RW'(LAT)) begin
      run_q <= run_q + RW'(1);
    end
  end

  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stall without a waiting result");

  // fixed latency when the output never stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q == RW'(LAT)) |-> (out_valid_o == $past(in_valid_i, LAT)))
    else $error("result valid does not match input transfer latency");

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped under stall");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(pulse_value_o))
    else $error("result changed under stall");

endmodule

bind pmt_pulse_shape_core pps_checker #(
  .AMP_BITS (AMP_BITS)
) u_pps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pulse_value_o (pulse_value_o)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the pmt pulse shape core against a bit-exact pulse predictor: directed
// samples around the pulse start, switch point and exponent limits, then random
// sample times under several register settings, with random idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int TB = 20;
  localparam int AB = 16;
  localparam int CW = 24;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [TB-1:0] sample_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [AB-1:0] pulse_value_o;
  logic cfg_we_i = 1'b0;
  logic [pps_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  // predictor copy of the registers
  logic        mode_q;
  logic [15:0] amp_q;
  logic [19:0] delay_q;
  logic [19:0] rlen_q;
  logic [23:0] rrate_q;
  logic [23:0] frate_q;
  logic [23:0] srate_q;
  logic [16:0] frac_q;

  logic [AB-1:0] pulse_q[$];
  int  fail_cnt = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;

  pmt_pulse_shape_core u_dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // exp(-a) in UQ2.30, a in UQ.24
  function automatic longint unsigned exp_neg_q30(longint unsigned a);
    longint unsigned y, v, e;
    if (a >= (longint'(16) << 24)) return 0;
    y = a << 2;
    v = 64'd1 << 30;
    for (int n = 12; n >= 1; n--)
      v = (64'd1 << 30) - ((y * v) >> 30) / n;
    e = v;
    for (int k = 0; k < 4; k++)
      e = (e * e + (64'd1 << 29)) >> 30;
    return e;
  endfunction

  function automatic logic [AB-1:0] pulse_at(logic [TB-1:0] t);
    longint unsigned dt, u, e, sw, d2, f, ef, es, mix, val;
    val = 0;
    if (mode_q) begin
      dt = (t >= delay_q) ? t - delay_q : delay_q - t;
      u = dt * rrate_q;
      if (u < (longint'(6) << 24)) begin
        e = exp_neg_q30((u * u) >> 25);
        val = (amp_q * e + (64'd1 << 29)) >> 30;
      end
    end else if (t >= delay_q) begin
      dt = t - delay_q;
      sw = 5 * longint'(rlen_q);
      if (dt <= sw) begin
        e = exp_neg_q30(dt * rrate_q);
        val = (amp_q * ((64'd1 << 30) - e) + (64'd1 << 29)) >> 30;
      end else begin
        d2 = dt - sw;
        f = (frac_q > pps_pkg::FRAC_ONE) ? 65536 : frac_q;
        ef = exp_neg_q30(d2 * frate_q);
        es = exp_neg_q30(d2 * srate_q);
        mix = (65536 - f) * ef + f * es;
        val = (amp_q * mix + (64'd1 << 45)) >> 46;
      end
    end
    return (val > 65535) ? 16'hFFFF : val[AB-1:0];
  endfunction

  // watchdog on transfers
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result check
  always @(posedge clk_i) begin
    logic [AB-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pulse_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, pulse_value_o);
        fail_cnt++;
      end else begin
        want = pulse_q.pop_front();
        if (pulse_value_o !== want) begin
          $display("%0t: pulse_value expected %0d actual %0d", $time, want, pulse_value_o);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i)
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 20);

  task automatic write_reg(pps_pkg::cfg_reg_e idx, logic [CW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pps_pkg::REG_SHAPE_MODE:    mode_q  = data[0];
      pps_pkg::REG_AMPLITUDE:     amp_q   = data[15:0];
      pps_pkg::REG_DELAY:         delay_q = data[19:0];
      pps_pkg::REG_RISE_LENGTH:   rlen_q  = data[19:0];
      pps_pkg::REG_RISE_RATE:     rrate_q = data;
      pps_pkg::REG_FALL_RATE:     frate_q = data;
      pps_pkg::REG_SLOW_RATE:     srate_q = data;
      pps_pkg::REG_SLOW_FRACTION: frac_q  = data[16:0];
      default: ;
    endcase
  endtask

  // one sample transfer, called at a falling edge; valid stays high after it
  task automatic send_sample(logic [TB-1:0] t);
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_time_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pulse_q.push_back(pulse_at(t));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pulse_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_shape(bit m, logic [15:0] a, logic [19:0] d, logic [19:0] rl,
                           logic [23:0] rr, logic [23:0] fr, logic [23:0] sr,
                           logic [16:0] sf);
    write_reg(pps_pkg::REG_SHAPE_MODE, CW'(m));
    write_reg(pps_pkg::REG_AMPLITUDE, CW'(a));
    write_reg(pps_pkg::REG_DELAY, CW'(d));
    write_reg(pps_pkg::REG_RISE_LENGTH, CW'(rl));
    write_reg(pps_pkg::REG_RISE_RATE, rr);
    write_reg(pps_pkg::REG_FALL_RATE, fr);
    write_reg(pps_pkg::REG_SLOW_RATE, sr);
    write_reg(pps_pkg::REG_SLOW_FRACTION, CW'(sf));
  endtask

  // points around start, switch point, field extremes
  task automatic test_directed();
    logic [19:0] sw;
    sw = 20'(delay_q + 5 * rlen_q);
    send_sample('0);
    send_sample('1);
    send_sample(20'hAAAAA);
    send_sample(20'h55555);
    send_sample(delay_q);
    send_sample(TB'(delay_q - 1));
    send_sample(TB'(delay_q + 1));
    send_sample(sw);
    send_sample(TB'(sw + 1));
    send_sample(TB'(sw - 1));
    send_sample(TB'(sw + 200));
    send_sample(TB'(sw + 5000));
  endtask

  task automatic test_random(int count, int span);
    logic [19:0] t;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) t = 20'($urandom);
      else t = 20'(delay_q + $urandom_range(span) - span / 8);
      send_sample(t);
    end
  endtask

  // sender holds back until the pipe is empty
  task automatic test_pause();
    send_sample(TB'(delay_q + 3));
    in_valid_i <= 1'b0;
    while (pulse_q.size() != 0) @(negedge clk_i);
    send_sample(TB'(delay_q + 40));
  endtask

  initial begin
    mode_q = 0; amp_q = 4096; delay_q = 0; rlen_q = 80;
    rrate_q = 209715; frate_q = 34953; srate_q = 1049; frac_q = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset defaults
    test_directed();
    test_random(150, 3000);
    wait_drained();

    // saturation, mixed decay
    set_shape(1'b0, 16'hFFFF, 20'd1000, 20'd20, 24'hFFFFFF, 24'd300000, 24'd2000, 17'd40000);
    test_directed();
    test_random(150, 4000);
    test_pause();
    wait_drained();

    // slow fraction above one, zero rates; then zero amplitude, fraction of one, extreme rates
    set_shape(1'b0, 16'd30000, 20'hFFF00, 20'd0, 24'd0, 24'd0, 24'd0, 17'h1FFFF);
    test_directed();
    test_random(80, 600);
    wait_drained();
    set_shape(1'b0, 16'd0, 20'd50, 20'hFFFFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 17'd65536);
    test_directed();
    test_random(60, 1000);
    wait_drained();

    // gaussian, with no idling stretch
    set_shape(1'b1, 16'd50000, 20'd5000, 20'd0, 24'd400000, 24'd1, 24'd1, 17'd0);
    test_directed();
    no_idle = 1'b1;
    test_random(250, 3000);
    no_idle = 1'b0;
    wait_drained();
    write_reg(pps_pkg::REG_RISE_RATE, 24'd0);
    test_random(50, 3000);
    wait_drained();
    write_reg(pps_pkg::REG_RISE_RATE, 24'hFFFFFF);
    write_reg(pps_pkg::REG_DELAY, CW'(20'hFFFFF));
    test_directed();
    test_random(80, 200);
    wait_drained();

    // random settings
    for (int p = 0; p < 4; p++) begin
      set_shape(1'($urandom_range(1)), 16'($urandom), 20'($urandom_range(20000)),
                20'($urandom_range(500)), 24'($urandom_range(2000000)),
                24'($urandom_range(500000)), 24'($urandom_range(20000)),
                17'($urandom_range(70000)));
      test_random(50, 8000);
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
